### rtl/core/vacuum_pump_release_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// Vacuum pump release controller assertion macros
// Shared assertion forms for the checker files of the block.
// ----------------------------------------------------------------------------
`ifndef VACUUM_PUMP_RELEASE_CONTROLLER_UNIT_DEFINES_SVH
`define VACUUM_PUMP_RELEASE_CONTROLLER_UNIT_DEFINES_SVH

// Check a property on every rising edge, skipped while reset is high.
`define VPRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define VPRC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/vprc_pkg.sv
// ----------------------------------------------------------------------------
// Vacuum pump release controller package
// Payload types, mode, status, command and register codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vprc_pkg;

   // Slot count the ports are sized for.
   localparam int SLOT_COUNT = 6;
   localparam int ID_W       = 29;
   localparam int CMD_W      = 8;
   localparam int CNT_W      = 3;
   localparam int TIME_W     = 32;
   localparam int REL_W      = 16;
   localparam int OFF_W      = 8;
   localparam int CSR_DATA_W = SLOT_COUNT * OFF_W;

   // Slot modes
   localparam logic [1:0] MODE_OFF       = 2'd0;
   localparam logic [1:0] MODE_ON        = 2'd1;
   localparam logic [1:0] MODE_RELEASING = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_MATCH = 2'd0;
   localparam logic [1:0] STATUS_MISS  = 2'd1;
   localparam logic [1:0] STATUS_TICK  = 2'd2;

   // Item kinds
   localparam logic ACTION_MESSAGE = 1'b0;
   localparam logic ACTION_TICK    = 1'b1;

   // Command byte codes
   localparam logic [CMD_W-1:0] CMD_STOP = 8'd0;
   localparam logic [CMD_W-1:0] CMD_RUN  = 8'd1;

   // Register indexes
   localparam logic [1:0] REG_PUMP_COUNT  = 2'd0;
   localparam logic [1:0] REG_BASE_CAN_ID = 2'd1;
   localparam logic [1:0] REG_ID_OFFSETS  = 2'd2;
   localparam logic [1:0] REG_RELEASE_TIME = 2'd3;

   typedef struct packed {
      logic             action;
      logic [ID_W-1:0]  can_id;
      logic [CMD_W-1:0] command;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_COUNT-1:0] pump_drive;
      logic [SLOT_COUNT-1:0] valve_drive;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]            reg_index;
      logic [CSR_DATA_W-1:0] wr_data;
   } csr_payload_type;

endpackage

### rtl/core/vprc_stream_if.sv
// ----------------------------------------------------------------------------
// Vacuum pump release controller stream channel
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vprc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/vacuum_pump_release_controller_unit.sv
// ----------------------------------------------------------------------------
// Vacuum pump release controller unit
// A req transfer reaches its rsp valid through the input reg, then the result reg.
// One item per cycle while the result channel does not stall; the slot state updates in a single pass.
// Reset (synchronous, active high) clears registers, slots, time and both stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vacuum_pump_release_controller_unit
   import vprc_pkg::*;
#(
   parameter int MAX_PUMPS = 6
) (
   input logic          clock,
   input logic          reset,
   vprc_stream_if.sink   req_chan,
   vprc_stream_if.source rsp_chan,
   vprc_stream_if.sink   csr_chan
);

   // -------------------------------------------------------------------------
   // Configuration registers; writes are always accepted.
   // -------------------------------------------------------------------------
   logic [CNT_W-1:0]      pump_count_ff;
   logic [ID_W-1:0]       base_can_id_ff;
   logic [CSR_DATA_W-1:0] id_offsets_ff;
   logic [REL_W-1:0]      release_time_ff;
   logic                  csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         pump_count_ff   <= '0;
         base_can_id_ff  <= '0;
         id_offsets_ff   <= '0;
         release_time_ff <= '0;
      end else if (csr_write) begin
         case (csr_chan.payload.reg_index)
            REG_PUMP_COUNT:   pump_count_ff   <= csr_chan.payload.wr_data[CNT_W-1:0];
            REG_BASE_CAN_ID:  base_can_id_ff  <= csr_chan.payload.wr_data[ID_W-1:0];
            REG_ID_OFFSETS:   id_offsets_ff   <= csr_chan.payload.wr_data;
            REG_RELEASE_TIME: release_time_ff <= csr_chan.payload.wr_data[REL_W-1:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Stage handshake: the result register frees when empty or taken; the
   // input register advances when empty or whenever the result register frees.
   // -------------------------------------------------------------------------
   logic            in_valid_ff;
   req_payload_type in_item_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_item_ff;
   logic            rsp_free;
   logic            process;
   logic            req_take;

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign process        = in_valid_ff && rsp_free;
   assign req_chan.ready = !in_valid_ff || rsp_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   // Capture the payload on each transfer; no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_chan.payload;
      end
   end

   // -------------------------------------------------------------------------
   // Slot state
   // -------------------------------------------------------------------------
   logic [TIME_W-1:0]    time_ff,  time_in;
   logic [1:0]           mode_ff   [MAX_PUMPS];
   logic [1:0]           mode_in   [MAX_PUMPS];
   logic [TIME_W-1:0]    start_ff  [MAX_PUMPS];
   logic [TIME_W-1:0]    start_in  [MAX_PUMPS];
   logic [MAX_PUMPS-1:0] pump_ff,  pump_in;
   logic [MAX_PUMPS-1:0] valve_ff, valve_in;
   logic [1:0]           status_in;

   // Active slot count; larger settings act as the full slot count.
   logic [CNT_W-1:0]     active_cnt;
   logic [MAX_PUMPS-1:0] slot_active;
   logic [MAX_PUMPS-1:0] id_hit;
   logic [MAX_PUMPS-1:0] first_hit;
   logic [ID_W-1:0]      slot_id   [MAX_PUMPS];
   logic [TIME_W-1:0]    elapsed   [MAX_PUMPS];

   assign active_cnt = (pump_count_ff > CNT_W'(MAX_PUMPS)) ? CNT_W'(MAX_PUMPS)
                                                           : pump_count_ff;

   // Compare all slot identifiers in parallel, then keep the lowest hit.
   always_comb begin
      for (int i = 0; i < MAX_PUMPS; i++) begin
         slot_active[i] = CNT_W'(i) < active_cnt;
         slot_id[i]     = base_can_id_ff + ID_W'(id_offsets_ff[i*OFF_W +: OFF_W]);
         id_hit[i]      = slot_active[i] && (slot_id[i] == in_item_ff.can_id);
      end
   end

   assign first_hit = id_hit & (~id_hit + MAX_PUMPS'(1));

   always_comb begin
      time_in   = time_ff;
      pump_in   = pump_ff;
      valve_in  = valve_ff;
      status_in = STATUS_MISS;
      for (int i = 0; i < MAX_PUMPS; i++) begin
         mode_in[i]  = mode_ff[i];
         start_in[i] = start_ff[i];
         elapsed[i]  = '0;
      end

      if (in_item_ff.action == ACTION_TICK) begin
         // Advance time, then drop every expired release of an active slot.
         time_in   = time_ff + TIME_W'(1);
         status_in = STATUS_TICK;
         for (int i = 0; i < MAX_PUMPS; i++) begin
            elapsed[i] = time_in - start_ff[i];
            if (slot_active[i] && (mode_ff[i] == MODE_RELEASING) &&
                (elapsed[i] >= TIME_W'(release_time_ff))) begin
               valve_in[i] = 1'b0;
               mode_in[i]  = MODE_OFF;
            end
         end
      end else begin
         if (|id_hit) begin
            status_in = STATUS_MATCH;
         end
         for (int i = 0; i < MAX_PUMPS; i++) begin
            if (first_hit[i]) begin
               case (in_item_ff.command)
                  CMD_STOP: begin
                     pump_in[i]  = 1'b0;
                     valve_in[i] = 1'b1;
                     mode_in[i]  = MODE_RELEASING;
                     start_in[i] = time_ff;
                  end
                  CMD_RUN: begin
                     pump_in[i]  = 1'b1;
                     valve_in[i] = 1'b0;
                     mode_in[i]  = MODE_ON;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   // Commit slot state only when an item is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= '0;
         pump_ff  <= '0;
         valve_ff <= '0;
         for (int i = 0; i < MAX_PUMPS; i++) begin
            mode_ff[i] <= MODE_OFF;
         end
      end else if (process) begin
         time_ff  <= time_in;
         pump_ff  <= pump_in;
         valve_ff <= valve_in;
         for (int i = 0; i < MAX_PUMPS; i++) begin
            mode_ff[i] <= mode_in[i];
         end
      end
   end

   // Release stamps are only read in releasing mode, so they need no reset.
   always_ff @(posedge clock) begin
      if (process) begin
         for (int i = 0; i < MAX_PUMPS; i++) begin
            start_ff[i] <= start_in[i];
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result register: load on process, drop after a transfer, hold otherwise.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_item_ff.status      <= status_in;
         rsp_item_ff.pump_drive  <= SLOT_COUNT'(pump_in);
         rsp_item_ff.valve_drive <= SLOT_COUNT'(valve_in);
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

endmodule

### rtl/core/vprc_checker.sv
// ----------------------------------------------------------------------------
// Vacuum pump release controller checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vacuum_pump_release_controller_unit_defines.svh"

module vprc_checker
   import vprc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_status,
   input logic [SLOT_COUNT-1:0] rsp_pump,
   input logic [SLOT_COUNT-1:0] rsp_valve
);

   // A stalled result must stay offered.
   `VPRC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped under stall")

   // A stalled result must not change.
   `VPRC_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable({rsp_status, rsp_pump, rsp_valve}), "rsp payload changed under stall")

   // A slot never drives its pump and its release valve together.
   `VPRC_ASSERT(a_drive_disjoint, clock, reset, rsp_valid |-> ((rsp_pump & rsp_valve) == '0), "pump and valve both on")

   // Reset empties the result stage.
   `VPRC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind vacuum_pump_release_controller_unit vprc_checker u_vprc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.payload.status),
   .rsp_pump   (rsp_chan.payload.pump_drive),
   .rsp_valve  (rsp_chan.payload.valve_drive)
);

### bench/vacuum_pump_release_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// Vacuum pump release controller unit testbench
// Sends a directed table of messages and ticks, then random phases under
// changing slot setups. Each result transfer is checked against a behavioral
// copy of the slot logic, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vacuum_pump_release_controller_unit_tb;
   import vprc_pkg::*;

   localparam int MAX_PUMPS    = 6;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 100;
   localparam int IDLE_PERCENT = 37;

   // One row of the directed table: a register write or an item, the item
   // optionally carrying a hand-written result.
   typedef struct {
      bit              is_write;
      csr_payload_type wr;
      req_payload_type item;
      bit              typed;
      rsp_payload_type want;
   } plan_row_type;

   logic clock;
   logic reset;

   vprc_stream_if #(.payload_type(req_payload_type)) req_if ();
   vprc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();
   vprc_stream_if #(.payload_type(csr_payload_type)) csr_if ();

   vacuum_pump_release_controller_unit #(
      .MAX_PUMPS(MAX_PUMPS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   // Register copies held by the predictor.
   bit [CNT_W-1:0]      cfg_pump_count;
   bit [ID_W-1:0]       cfg_base_id;
   bit [CSR_DATA_W-1:0] cfg_offsets;
   bit [REL_W-1:0]      cfg_release_ms;

   // Slot state held by the predictor; 2-state types start at reset values.
   bit [TIME_W-1:0]     ms_count;
   bit [1:0]            slot_mode  [SLOT_COUNT];
   bit [TIME_W-1:0]     stop_stamp [SLOT_COUNT];
   bit [SLOT_COUNT-1:0] pump_state;
   bit [SLOT_COUNT-1:0] valve_state;

   rsp_payload_type drive_queue[$];
   plan_row_type    plan[$];
   int              mismatch_count;
   bit              steady;

   // Clock: 20 ns period.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop for a hung handshake.
   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   function automatic void apply_register(logic [1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_PUMP_COUNT:   cfg_pump_count = data[CNT_W-1:0];
         REG_BASE_CAN_ID:  cfg_base_id    = data[ID_W-1:0];
         REG_ID_OFFSETS:   cfg_offsets    = data;
         REG_RELEASE_TIME: cfg_release_ms = data[REL_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [ID_W-1:0] slot_can_id(int slot);
      logic [ID_W-1:0] id;
      // Keep the sum to 29 bits: the carry out of the base drops.
      id = cfg_base_id + ID_W'(cfg_offsets[slot*OFF_W +: OFF_W]);
      return id;
   endfunction

   // Advance the slot state by one item and return the drive it leaves.
   function automatic rsp_payload_type step_controller(req_payload_type item);
      rsp_payload_type result;
      int              live;
      logic [TIME_W-1:0] elapsed;
      // Counts above the slot total act as the slot total.
      live = (cfg_pump_count > MAX_PUMPS) ? MAX_PUMPS : int'(cfg_pump_count);
      if (item.action == ACTION_TICK) begin
         ms_count = ms_count + TIME_W'(1);
         for (int i = 0; i < live; i++) begin
            elapsed = ms_count - stop_stamp[i];
            if (slot_mode[i] == MODE_RELEASING && elapsed >= TIME_W'(cfg_release_ms)) begin
               valve_state[i] = 1'b0;
               slot_mode[i]   = MODE_OFF;
            end
         end
         result.status = STATUS_TICK;
      end else begin
         result.status = STATUS_MISS;
         for (int i = 0; i < live; i++) begin
            // First matching slot wins; any other command byte is a no-op match.
            if (result.status == STATUS_MISS && slot_can_id(i) == item.can_id) begin
               if (item.command == CMD_STOP) begin
                  pump_state[i]  = 1'b0;
                  valve_state[i] = 1'b1;
                  slot_mode[i]   = MODE_RELEASING;
                  stop_stamp[i]  = ms_count;
               end else if (item.command == CMD_RUN) begin
                  pump_state[i]  = 1'b1;
                  valve_state[i] = 1'b0;
                  slot_mode[i]   = MODE_ON;
               end
               result.status = STATUS_MATCH;
            end
         end
      end
      result.pump_drive  = pump_state;
      result.valve_drive = valve_state;
      return result;
   endfunction

   // ------------------------------------------------------------------------
   // Directed table builders
   // ------------------------------------------------------------------------

   function automatic void add_write(logic [1:0] idx, logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row = '{default: '0};
      row.is_write     = 1'b1;
      row.wr.reg_index = idx;
      row.wr.wr_data   = data;
      plan.push_back(row);
   endfunction

   function automatic void add_item(logic act, logic [ID_W-1:0] id, logic [CMD_W-1:0] cmd);
      plan_row_type row;
      row = '{default: '0};
      row.item.action  = act;
      row.item.can_id  = id;
      row.item.command = cmd;
      plan.push_back(row);
   endfunction

   function automatic void add_typed(logic act, logic [ID_W-1:0] id, logic [CMD_W-1:0] cmd,
                                     logic [1:0] st, logic [5:0] pumps, logic [5:0] valves);
      add_item(act, id, cmd);
      plan[$].typed            = 1'b1;
      plan[$].want.status      = st;
      plan[$].want.pump_drive  = pumps;
      plan[$].want.valve_drive = valves;
   endfunction

   // ------------------------------------------------------------------------
   // Random stimulus
   // ------------------------------------------------------------------------

   function automatic req_payload_type make_random_item();
      req_payload_type item;
      int              roll;
      int              r;
      roll = $urandom_range(0, 99);
      item.can_id  = ID_W'($urandom);
      item.command = CMD_W'($urandom);
      if (roll < 40) begin
         // Tick: the identifier and command still toggle, and are ignored.
         item.action = ACTION_TICK;
      end else begin
         item.action = ACTION_MESSAGE;
         if (roll < 88) begin
            // Aim at a slot, active or not, mostly with run or stop.
            item.can_id = slot_can_id($urandom_range(0, SLOT_COUNT - 1));
            r = $urandom_range(0, 99);
            if (r < 45)
               item.command = CMD_STOP;
            else if (r < 90)
               item.command = CMD_RUN;
         end
      end
      return item;
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------

   // Offer one item, idling at random first; record its expected drive on transfer.
   task automatic send_item(req_payload_type item, bit typed, rsp_payload_type want);
      rsp_payload_type predicted;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = step_controller(item);
      drive_queue.push_back(typed ? want : predicted);
   endtask

   // Drop the request valid and hold until every expected result has arrived.
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (drive_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_payload_type wr;
      wr.reg_index = idx;
      wr.wr_data   = data;
      @(negedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= wr;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      apply_register(idx, data);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Result side: stall at random except in the steady stretch.
   always @(negedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (drive_queue.size() == 0) begin
            $error("unexpected result transfer: status %0d", rsp_if.payload.status);
            mismatch_count++;
         end else begin
            want = drive_queue.pop_front();
            if (rsp_if.payload.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_if.payload.status);
               mismatch_count++;
            end
            if (rsp_if.payload.pump_drive !== want.pump_drive) begin
               $error("pump_drive: expected %b, actual %b",
                      want.pump_drive, rsp_if.payload.pump_drive);
               mismatch_count++;
            end
            if (rsp_if.payload.valve_drive !== want.valve_drive) begin
               $error("valve_drive: expected %b, actual %b",
                      want.valve_drive, rsp_if.payload.valve_drive);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin
      rsp_payload_type no_want;
      logic [CSR_DATA_W-1:0] offsets;
      logic [REL_W-1:0]      hold_ms;
      no_want        = '0;
      mismatch_count = 0;
      steady         = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;

      // Directed table. With reset registers no slot is in use.
      add_typed(ACTION_MESSAGE, 29'h0, CMD_RUN, STATUS_MISS, 6'b000000, 6'b000000);
      add_typed(ACTION_TICK, 29'h0, CMD_STOP, STATUS_TICK, 6'b000000, 6'b000000);
      // Oversized count acts as six slots; max base wraps slot one to zero.
      // Slot ids: 1FFFFFFF, 0, FE, 7, 8, 9. Zero release time.
      add_write(REG_PUMP_COUNT, 48'd7);
      add_write(REG_BASE_CAN_ID, 48'h1FFF_FFFF);
      add_write(REG_ID_OFFSETS, 48'h0A_09_08_FF_01_00);
      add_write(REG_RELEASE_TIME, 48'd0);
      add_typed(ACTION_MESSAGE, 29'h1FFF_FFFF, CMD_RUN, STATUS_MATCH, 6'b000001, 6'b000000);
      add_typed(ACTION_MESSAGE, 29'h0, CMD_RUN, STATUS_MATCH, 6'b000011, 6'b000000);
      add_typed(ACTION_MESSAGE, 29'h9, CMD_RUN, STATUS_MATCH, 6'b100011, 6'b000000);
      add_typed(ACTION_MESSAGE, 29'h0, CMD_STOP, STATUS_MATCH, 6'b100001, 6'b000010);
      // Zero release time: the next tick closes the valve.
      add_typed(ACTION_TICK, 29'h0, CMD_STOP, STATUS_TICK, 6'b100001, 6'b000000);
      // Other command bytes match and change nothing.
      add_typed(ACTION_MESSAGE, 29'hFE, 8'hFF, STATUS_MATCH, 6'b100001, 6'b000000);
      add_typed(ACTION_MESSAGE, 29'h7, 8'h80, STATUS_MATCH, 6'b100001, 6'b000000);
      add_typed(ACTION_MESSAGE, 29'h0AB_CDEF, CMD_RUN, STATUS_MISS, 6'b100001, 6'b000000);
      add_typed(ACTION_MESSAGE, 29'h8, CMD_STOP, STATUS_MATCH, 6'b100001, 6'b010000);
      // Three slots in use, all sharing one id: only the first matches.
      // Slot four stays releasing while inactive and its valve bit shows.
      add_write(REG_PUMP_COUNT, 48'd3);
      add_write(REG_BASE_CAN_ID, 48'h0AB_CDEF);
      add_write(REG_ID_OFFSETS, 48'h0);
      add_write(REG_RELEASE_TIME, 48'hFFFF);
      add_typed(ACTION_MESSAGE, 29'h0AB_CDEF, CMD_RUN, STATUS_MATCH, 6'b100001, 6'b010000);
      add_typed(ACTION_MESSAGE, 29'h0AB_CDEF, CMD_STOP, STATUS_MATCH, 6'b100000, 6'b010001);
      add_typed(ACTION_TICK, 29'h1FFF_FFFF, 8'hFF, STATUS_TICK, 6'b100000, 6'b010001);
      add_item(ACTION_MESSAGE, 29'h9, CMD_RUN);
      // Repeated stop restamps; two ticks later the valve closes.
      add_write(REG_RELEASE_TIME, 48'd2);
      add_item(ACTION_MESSAGE, 29'h0AB_CDEF, CMD_STOP);
      add_item(ACTION_TICK, 29'h0, CMD_STOP);
      add_item(ACTION_TICK, 29'h0, CMD_STOP);
      add_item(ACTION_TICK, 29'h0, CMD_STOP);
      add_item(ACTION_MESSAGE, 29'h0AB_CDEF, 8'h02);

      // Hold reset, then release it at a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table; register writes only with the block drained.
      foreach (plan[k]) begin
         if (plan[k].is_write) begin
            wait_idle();
            write_register(plan[k].wr.reg_index, plan[k].wr.wr_data);
         end else begin
            send_item(plan[k].item, plan[k].typed, plan[k].want);
         end
      end

      // Random phases, each with a fresh setup of every register.
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         steady  = (p == 3);
         offsets = {16'($urandom), 32'($urandom)};
         hold_ms = ($urandom_range(0, 3) == 0) ? REL_W'($urandom)
                                               : REL_W'($urandom_range(0, 6));
         if (p == 0) begin
            // Extremes: oversized count, top base, zero hold.
            write_register(REG_PUMP_COUNT, 48'd7);
            write_register(REG_BASE_CAN_ID, 48'h1FFF_FFFF);
            write_register(REG_ID_OFFSETS, offsets);
            write_register(REG_RELEASE_TIME, 48'd0);
         end else if (p == 1) begin
            // Extremes: full count, zero base, identical offsets, longest hold.
            write_register(REG_PUMP_COUNT, 48'd6);
            write_register(REG_BASE_CAN_ID, 48'd0);
            write_register(REG_ID_OFFSETS, 48'hFFFF_FFFF_FFFF);
            write_register(REG_RELEASE_TIME, 48'hFFFF);
         end else begin
            write_register(REG_PUMP_COUNT, 48'($urandom_range(0, 7)));
            write_register(REG_BASE_CAN_ID, 48'(ID_W'($urandom)));
            write_register(REG_ID_OFFSETS, offsets);
            write_register(REG_RELEASE_TIME, 48'(hold_ms));
         end
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_item(make_random_item(), 1'b0, no_want);
      end

      // Drain, then allow the pipeline latency before the verdict.
      wait_idle();
      steady = 1'b0;
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
